>>> hw/rtl/kpsd_pkg.sv
// ============================================================================
// kpsd_pkg - shared types and constants for the order-statistic count tree
// Holds the sequencer state type, the level step control bundle and the
// fixed field widths of the stream interface.
// ============================================================================
package kpsd_pkg;

	// Width of the rank field carried in the input transaction.
	localparam int unsigned RANK_W = 17;
	// Width of the position field carried in the result transaction.
	localparam int unsigned POS_W = 16;
	// Byte-padded tdata widths of the two channels.
	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned M_DATA_W = 16;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Decision of one tree level, handed from the step unit to the sequencer.
	typedef struct packed {
		logic at_leaf;
		logic go_right;
	} step_ctl_t;

endpackage

>>> hw/rtl/kth_present_select_delete_core.sv
// ============================================================================
// kth_present_select_delete_core - select or delete the k-th present position
// An input transaction is accepted only in the idle state, so no new item is
// taken until the result of the last one is registered. The descent visits one
// tree level per cycle through the shared level step unit; a rank out of range
// skips the descent and goes straight to the result.
// Reset: a clearing pass over all 2*2^clog2(LEAVES) node entries zeroes the
// node memory while s_tready stays low; every position is present.
// ============================================================================
module kth_present_select_delete_core #(
	parameter int unsigned LEAVES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: rank [16:0], zero padding [23:17]
	input  logic [kpsd_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: operation [0] (0 select, 1 select and delete)
	input  logic [0:0]                    s_tuser,
	// Result channel.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: position [15:0]
	output logic [kpsd_pkg::M_DATA_W-1:0] m_tdata,
	// m_tuser: found [0]
	output logic [0:0]                    m_tuser
);

	localparam int unsigned PW    = $clog2(LEAVES);
	localparam int unsigned CW    = $clog2(LEAVES + 1);
	localparam int unsigned KW    = kpsd_pkg::RANK_W;
	localparam int unsigned CMPW  = (CW > KW) ? CW : KW;
	localparam int unsigned AW    = PW + 1;
	localparam int unsigned NODES = 2 ** AW;
	localparam int unsigned OUTW  = kpsd_pkg::POS_W;

	// The memory holds, for each heap node, how many positions below it have
	// been deleted. The live count is the subtree size minus that figure, so
	// a cleared memory stands for the full set. The root is kept in flops as
	// the present count, since the range check needs it at once.
	logic [CW-1:0] del_mem [NODES];

	kpsd_pkg::state_t    state_q;
	kpsd_pkg::state_t    state_d;
	kpsd_pkg::step_ctl_t step_ctl;

	logic [AW-1:0]   clr_addr_q;
	logic [CW-1:0]   present_q;
	logic            op_q;
	logic            found_q;
	logic [KW-1:0]   k_q;
	logic [AW-1:0]   node_q;
	logic [PW-1:0]   lo_q;
	logic [PW-1:0]   hi_q;
	logic [CW-1:0]   del_node_q;
	logic [CW-1:0]   rd_left_q;
	logic [CW-1:0]   rd_right_q;
	logic            m_tvalid_q;
	logic [OUTW-1:0] m_pos_q;
	logic            m_found_q;

	logic            s_fire;
	logic            out_free;
	logic [KW-1:0]   s_rank;
	logic            in_range;
	logic [PW-1:0]   next_lo;
	logic [PW-1:0]   next_hi;
	logic [KW-1:0]   next_k;
	logic [CW-1:0]   next_del;
	logic [AW:0]     left_full;
	logic [AW:0]     right_full;
	logic [AW-1:0]   next_node;
	logic [AW-1:0]   rd_base;
	logic [AW:0]     rd_left_full;
	logic [AW:0]     rd_right_full;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [CW-1:0]   mem_wdata;
	logic            root_dec;
	logic [PW+OUTW-1:0] lo_ext;

	assign s_rank   = s_tdata[KW-1:0];
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign in_range = (s_rank != '0) && (CMPW'(s_rank) <= CMPW'(present_q));

	// The shared level unit: one pass through it per tree level.
	kpsd_level_step #(
		.LEAVES (LEAVES)
	) u_step (
		.lo        (lo_q),
		.hi        (hi_q),
		.k         (k_q),
		.del_left  (rd_left_q),
		.del_right (rd_right_q),
		.ctl       (step_ctl),
		.next_lo   (next_lo),
		.next_hi   (next_hi),
		.next_k    (next_k),
		.next_del  (next_del)
	);

	// Heap children of the current node, and of the node about to be
	// entered so that its children's counts arrive in time for the next level.
	always_comb begin
		left_full  = {node_q, 1'b1};
		right_full = {node_q, 1'b1} + (AW + 1)'(1);
		next_node  = step_ctl.go_right ? right_full[AW-1:0] : left_full[AW-1:0];
		rd_base    = (state_q == kpsd_pkg::ST_IDLE) ? '0 : next_node;
		// Reads past a leaf fetch unused entries; the address wraps harmlessly.
		rd_left_full  = {rd_base, 1'b1};
		rd_right_full = {rd_base, 1'b1} + (AW + 1)'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpsd_pkg::ST_CLEAR: begin
				if (&clr_addr_q) state_d = kpsd_pkg::ST_IDLE;
			end
			kpsd_pkg::ST_IDLE: begin
				if (s_fire) state_d = in_range ? kpsd_pkg::ST_WALK : kpsd_pkg::ST_FINISH;
			end
			kpsd_pkg::ST_WALK: begin
				if (step_ctl.at_leaf) state_d = kpsd_pkg::ST_FINISH;
			end
			kpsd_pkg::ST_FINISH: begin
				if (out_free) state_d = kpsd_pkg::ST_IDLE;
			end
			default: state_d = kpsd_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer: handshake and memory write port.
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = del_node_q + CW'(1);
		root_dec  = 1'b0;
		unique case (state_q)
			kpsd_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			kpsd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			kpsd_pkg::ST_WALK: begin
				// A delete charges every node on the path, leaf included.
				if (op_q) begin
					if (node_q == '0) begin
						root_dec = 1'b1;
					end else begin
						mem_we = 1'b1;
					end
				end
			end
			kpsd_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Node memory: at most one write and two registered reads each cycle.
	always_ff @(posedge clk) begin
		if (mem_we) del_mem[mem_waddr] <= mem_wdata;
		rd_left_q  <= del_mem[rd_left_full[AW-1:0]];
		rd_right_q <= del_mem[rd_right_full[AW-1:0]];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kpsd_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			present_q  <= CW'(LEAVES);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kpsd_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
			if (root_dec) present_q <= present_q - CW'(1);
			if (state_q == kpsd_pkg::ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Walk registers and the result register.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q    <= s_tuser[0];
			k_q     <= s_rank;
			node_q  <= '0;
			lo_q    <= '0;
			hi_q    <= PW'(LEAVES - 1);
			found_q <= in_range;
		end else if (state_q == kpsd_pkg::ST_WALK && !step_ctl.at_leaf) begin
			node_q     <= next_node;
			lo_q       <= next_lo;
			hi_q       <= next_hi;
			k_q        <= next_k;
			del_node_q <= next_del;
		end
		if (state_q == kpsd_pkg::ST_FINISH && out_free) begin
			m_pos_q   <= lo_ext[OUTW-1:0];
			m_found_q <= found_q;
		end
	end

	// Only the low bits of the position are reported.
	assign lo_ext = {{OUTW{1'b0}}, lo_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_pos_q;
	assign m_tuser  = m_found_q;

	// The present count can only fall from the full set.
	a_present_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(present_q) <= CMPW'(LEAVES))
		else $error("present count above the number of leaves");

	// The present count moves only on a delete step at the root.
	a_present_only_delete: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(present_q) |-> $past(state_q == kpsd_pkg::ST_WALK && op_q && node_q == '0))
		else $error("present count changed outside a delete");

	// During the descent the range is never empty and the rank stays positive.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kpsd_pkg::ST_WALK |-> (lo_q <= hi_q) && (k_q != '0))
		else $error("descent left its range or lost its rank");

	// A miss always reports position zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss reported a non-zero position");

endmodule

>>> hw/rtl/kpsd_level_step.sv
// ============================================================================
// kpsd_level_step - one level of the count tree descent
// Splits the current range at its midpoint, forms the live count of the left
// subtree from its size and its deletion count, and picks the child to enter.
// ============================================================================
module kpsd_level_step #(
	parameter int unsigned LEAVES = 65536
) (
	input  logic [$clog2(LEAVES)-1:0]   lo,
	input  logic [$clog2(LEAVES)-1:0]   hi,
	input  logic [kpsd_pkg::RANK_W-1:0] k,
	input  logic [$clog2(LEAVES+1)-1:0] del_left,
	input  logic [$clog2(LEAVES+1)-1:0] del_right,
	output kpsd_pkg::step_ctl_t         ctl,
	output logic [$clog2(LEAVES)-1:0]   next_lo,
	output logic [$clog2(LEAVES)-1:0]   next_hi,
	output logic [kpsd_pkg::RANK_W-1:0] next_k,
	output logic [$clog2(LEAVES+1)-1:0] next_del
);

	localparam int unsigned PW   = $clog2(LEAVES);
	localparam int unsigned CW   = $clog2(LEAVES + 1);
	localparam int unsigned KW   = kpsd_pkg::RANK_W;
	localparam int unsigned CMPW = (CW > KW) ? CW : KW;

	logic [PW:0]     mid_w;
	logic [PW-1:0]   mid;
	logic [PW-1:0]   diff_l;
	logic [CW-1:0]   lsize;
	logic [CW-1:0]   lcount;
	logic [CMPW-1:0] k_ext;
	logic [CMPW-1:0] lcount_ext;
	logic [CMPW-1:0] k_diff;

	always_comb begin
		mid_w      = ({1'b0, lo} + {1'b0, hi}) >> 1;
		mid        = mid_w[PW-1:0];
		diff_l     = mid - lo;
		lsize      = CW'(diff_l) + CW'(1);
		lcount     = lsize - del_left;
		k_ext      = CMPW'(k);
		lcount_ext = CMPW'(lcount);
		k_diff     = k_ext - lcount_ext;

		ctl.at_leaf  = (lo == hi);
		ctl.go_right = (k_ext > lcount_ext);

		next_lo  = ctl.go_right ? (mid + PW'(1)) : lo;
		next_hi  = ctl.go_right ? hi : mid;
		next_k   = ctl.go_right ? k_diff[KW-1:0] : k;
		next_del = ctl.go_right ? del_right : del_left;
	end

endmodule

>>> sim/kpsd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_tb_pkg - operation codes shared by the count tree testbench
// The stimulus and the checker both decode the single tuser bit of the input
// channel, so its two meanings are named here once.
// ----------------------------------------------------------------------------
package kpsd_tb_pkg;

	typedef enum logic [0:0] {
		OP_SELECT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

endpackage

>>> sim/kpsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_checker - result predictor and comparator for the count tree
// Watches both stream channels, keeps a private count tree of present
// positions, predicts one result per accepted input transaction and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module kpsd_checker #(
	parameter int unsigned LEAVES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// s_tdata: rank [16:0], zero padding [23:17]
	input  logic [kpsd_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: operation [0]
	input  logic [0:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: position [15:0]
	input  logic [kpsd_pkg::M_DATA_W-1:0] m_tdata,
	// m_tuser: found [0]
	input  logic [0:0]                    m_tuser,
	output int unsigned                   fail_count,
	output int unsigned                   outstanding
);

	localparam int unsigned DEPTH = $clog2(LEAVES);

	typedef struct packed {
		logic [kpsd_pkg::POS_W-1:0] position;
		logic                       found;
	} pick_t;

	// Heap numbered from 1: node n has children 2n and 2n+1, leaves start at LEAVES.
	logic [kpsd_pkg::RANK_W-1:0] tally [1:2*LEAVES-1];
	pick_t                       due_picks [$];

	initial begin
		for (int unsigned n = LEAVES; n < 2 * LEAVES; n++)
			tally[n] = 1;
		for (int unsigned n = LEAVES - 1; n >= 1; n--)
			tally[n] = tally[2 * n] + tally[2 * n + 1];
	end

	// Finds the rank-th present position and, for a delete, takes one off every
	// count on the way down to it.
	function automatic pick_t take_kth(input kpsd_tb_pkg::op_t op,
		input logic [kpsd_pkg::RANK_W-1:0] rank);
		pick_t                       res;
		int unsigned                 node;
		logic [kpsd_pkg::RANK_W-1:0] k;
		res  = '0;
		node = 1;
		k    = rank;
		if (rank == 0 || rank > tally[1])
			return res;
		for (int unsigned lvl = 0; lvl < DEPTH; lvl++) begin
			if (op == kpsd_tb_pkg::OP_DELETE)
				tally[node] = tally[node] - 1;
			if (k <= tally[2 * node]) begin
				node = 2 * node;
			end else begin
				k    = k - tally[2 * node];
				node = 2 * node + 1;
			end
		end
		if (op == kpsd_tb_pkg::OP_DELETE)
			tally[node] = tally[node] - 1;
		res.position = kpsd_pkg::POS_W'(node - LEAVES);
		res.found    = 1'b1;
		return res;
	endfunction

	always @(posedge clk) begin
		pick_t want;
		if (!arst_n) begin
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				due_picks.push_back(take_kth(kpsd_tb_pkg::op_t'(s_tuser[0]),
					s_tdata[kpsd_pkg::RANK_W-1:0]));
			if (m_tvalid && m_tready) begin
				if (due_picks.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%0t: result with nothing outstanding: position %0d found %0d",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = due_picks.pop_front();
					if (m_tdata !== want.position || m_tuser[0] !== want.found) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("%0t: mismatch: position exp %0d got %0d, found exp %0d got %0d",
								$realtime, want.position, m_tdata, want.found, m_tuser);
					end
				end
			end
			outstanding <= due_picks.size();
		end
	end

endmodule

>>> sim/kth_present_select_delete_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_present_select_delete_core_tb - stimulus and verdict for the count tree
// Drives select and delete requests into the core, with directed boundary
// ranks first and then a long random run that keeps most ranks inside the
// present count. Both channels idle at random. A separate checker predicts
// and compares every result; this module only gives the final verdict.
// ----------------------------------------------------------------------------
module kth_present_select_delete_core_tb;

	localparam int unsigned LEAVES = 65536;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [kpsd_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic [0:0]                    s_tuser  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [kpsd_pkg::M_DATA_W-1:0] m_tdata;
	logic [0:0]                    m_tuser;
	int unsigned                   fail_count;
	int unsigned                   outstanding;

	// Number of positions still present, tracked so that ranks can be aimed
	// at the interesting region of the tree.
	int unsigned                   live = LEAVES;
	// While set, neither side idles, giving back-to-back stretches.
	logic                          quiet = 1'b0;
	int unsigned                   sink_hold = 0;
	int unsigned                   stall_len;

	kth_present_select_delete_core #(.LEAVES(LEAVES)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	kpsd_checker #(.LEAVES(LEAVES)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Idle length in cycles: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The result side alternates between runs of readiness and stalls. A stall
	// of zero length simply extends the current ready run.
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
			sink_hold = 0;
		end else if (sink_hold != 0) begin
			sink_hold = sink_hold - 1;
		end else if (m_tready) begin
			stall_len = pick_gap();
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				sink_hold = stall_len - 1;
			end else begin
				sink_hold = $urandom_range(0, 8);
			end
		end else begin
			m_tready <= 1'b1;
			sink_hold = $urandom_range(0, 20);
		end
	end

	// Offers one request, entered and left at a falling edge. With no gap the
	// valid simply stays high and only the payload changes.
	task automatic offer_rank(input kpsd_tb_pkg::op_t op, input int unsigned rank);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = kpsd_pkg::S_DATA_W'(rank);
		s_tuser  = op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == kpsd_tb_pkg::OP_DELETE && rank >= 1 && rank <= live)
			live = live - 1;
		@(negedge clk);
	endtask

	// Rank chooser for the random part: most ranks fall inside the present
	// count, with extra weight on the two ends where deletions pile up.
	function automatic int unsigned draw_rank();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(1, live);
		if (r < 60)
			return $urandom_range(1, 16);
		if (r < 75)
			return $urandom_range(live > 8 ? live - 8 : 1, live);
		if (r < 85)
			return $urandom_range(live + 1, live + 3);
		if (r < 90)
			return 0;
		return $urandom_range(0, (1 << kpsd_pkg::RANK_W) - 1);
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. The first request also waits out the clearing pass.
		offer_rank(kpsd_tb_pkg::OP_SELECT, 0);
		offer_rank(kpsd_tb_pkg::OP_SELECT, 1);
		offer_rank(kpsd_tb_pkg::OP_SELECT, LEAVES);
		offer_rank(kpsd_tb_pkg::OP_SELECT, LEAVES + 1);
		offer_rank(kpsd_tb_pkg::OP_SELECT, (1 << kpsd_pkg::RANK_W) - 1);
		offer_rank(kpsd_tb_pkg::OP_DELETE, 0);
		offer_rank(kpsd_tb_pkg::OP_DELETE, (1 << kpsd_pkg::RANK_W) - 1);
		offer_rank(kpsd_tb_pkg::OP_DELETE, LEAVES + 1);
		// Remove the lowest position and look just past it.
		offer_rank(kpsd_tb_pkg::OP_DELETE, 1);
		offer_rank(kpsd_tb_pkg::OP_SELECT, 1);
		// Remove the highest position, then probe the new upper boundary.
		offer_rank(kpsd_tb_pkg::OP_DELETE, live);
		offer_rank(kpsd_tb_pkg::OP_SELECT, live);
		offer_rank(kpsd_tb_pkg::OP_SELECT, live + 1);
		offer_rank(kpsd_tb_pkg::OP_DELETE, live + 1);
		// Delete across the middle, where the root splits.
		offer_rank(kpsd_tb_pkg::OP_DELETE, LEAVES / 2);
		offer_rank(kpsd_tb_pkg::OP_SELECT, LEAVES / 2);
		offer_rank(kpsd_tb_pkg::OP_SELECT, LEAVES / 2 - 1);
		// Repeated deletes at the bottom empty a whole small subtree.
		repeat (4) offer_rank(kpsd_tb_pkg::OP_DELETE, 1);
		offer_rank(kpsd_tb_pkg::OP_SELECT, 1);
		offer_rank(kpsd_tb_pkg::OP_DELETE, live);
		offer_rank(kpsd_tb_pkg::OP_SELECT, live);

		// Hold the sender back until every result so far has arrived.
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);

		for (int i = 0; i < 430; i++) begin
			quiet = (i >= 150 && i < 210);
			offer_rank($urandom_range(0, 1) ? kpsd_tb_pkg::OP_DELETE : kpsd_tb_pkg::OP_SELECT,
				draw_rank());
		end
		quiet    = 1'b0;
		s_tvalid = 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: the clearing pass plus the slowest legal run fit well inside this.
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
